// ----- src/lagrange_interpolator_assert.svh -----
// assertion macros for the checker of the interpolator
// no dependencies; include by bare file name
`ifndef LAGRANGE_INTERPOLATOR_ASSERT_SVH
`define LAGRANGE_INTERPOLATOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define LI_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lagrange_interpolator: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define LI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lagrange_interpolator: next-cycle check failed");

`endif

// ----- src/li_pkg.sv -----
// shared types and constants of the lagrange interpolator
// no dependencies; imported by every module of the block but li_ram
`default_nettype none

package li_pkg;

  // stream payload widths
  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;

  // single precision constants
  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_ZERO = 32'h0000_0000;
  localparam logic [31:0] FP_DNAN = 32'hFFC0_0000;
  localparam logic [31:0] FP_QBIT = 32'h0040_0000;

  // request kinds carried in tuser bit 0
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } fpu_op_t;

  // which operation of the algorithm the float unit runs, and where the result goes
  typedef enum logic [2:0] {
    ST_SUB1,   // xi - xj
    ST_SUB2,   // xp - xj
    ST_MULP,   // prod * diff
    ST_DIV,    // f_i / prod, into weight store
    ST_MULW,   // w_i * prod
    ST_ADD     // acc + term
  } step_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_ADD,
    F_MUL,
    F_PRE,
    F_DIV,
    F_NORM,
    F_RND,
    F_DONE
  } fpu_state_t;

  typedef enum logic [4:0] {
    C_IDLE,
    C_RD_XI,
    C_LD_XI,
    C_J,
    C_SUB,
    C_SUB_W,
    C_MUL,
    C_MUL_W,
    C_RD_F,
    C_DIV,
    C_DIV_W,
    C_P2_I,
    C_RD_W,
    C_MULW,
    C_MULW_W,
    C_ADD,
    C_ADD_W,
    C_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic  in_ready;
    logic  query_start;
    logic  i_clr;
    logic  i_inc;
    logic  j_clr;
    logic  j_inc;
    logic  x_re;
    logic  x_at_j;
    logic  f_re;
    logic  w_re;
    logic  ld_xi;
    logic  prod_one;
    logic  fpu_start;
    step_t step;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_query;
    logic n_zero;
    logic j_eq_n;
    logic j_eq_i;
    logic i_last;
    logic fpu_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- src/li_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module li_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/li_fpu.sv -----
// multi-cycle single precision unit: add, subtract, multiply, divide
// round to nearest even, subnormals kept; depends on li_pkg
`default_nettype none

module li_fpu (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire li_pkg::fpu_op_t op,
  input  wire logic [31:0]    a,
  input  wire logic [31:0]    b,
  output logic                done,
  output logic [31:0]         res
);
  import li_pkg::*;

  fpu_state_t ph, ph_next;

  logic               sa, sb, s, zs;
  logic signed [11:0] ea, eb, e;
  logic [23:0]        ma, mb;
  logic [49:0]        m;
  logic [26:0]        q;
  logic [25:0]        r;
  logic [4:0]         k;

  // operand classes
  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sbe, sx, special;
  logic [31:0] spec_val;

  function automatic logic signed [11:0] unp_exp(input logic [7:0] f);
    if (f == 8'd0) begin
      return -12'sd126;
    end
    return $signed({4'b0000, f}) - 12'sd127;
  endfunction

  always_comb begin
    a_nan  = (&a[30:23]) && (|a[22:0]);
    b_nan  = (&b[30:23]) && (|b[22:0]);
    a_inf  = (&a[30:23]) && !(|a[22:0]);
    b_inf  = (&b[30:23]) && !(|b[22:0]);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    sbe    = (op == OP_SUB) ? ~b[31] : b[31];
    sx     = a[31] ^ b[31];
    special  = 1'b1;
    spec_val = FP_DNAN;
    if (a_nan) begin
      spec_val = a | FP_QBIT;
    end else if (b_nan) begin
      spec_val = b | FP_QBIT;
    end else begin
      unique case (op)
        OP_ADD, OP_SUB: begin
          if (a_inf && b_inf && (a[31] != sbe)) begin
            spec_val = FP_DNAN;
          end else if (a_inf) begin
            spec_val = a;
          end else if (b_inf) begin
            spec_val = {sbe, 8'hFF, 23'd0};
          end else begin
            special = 1'b0;
          end
        end
        OP_MUL: begin
          if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            spec_val = FP_DNAN;
          end else if (a_inf || b_inf) begin
            spec_val = {sx, 8'hFF, 23'd0};
          end else begin
            special = 1'b0;
          end
        end
        OP_DIV: begin
          if ((a_inf && b_inf) || (a_zero && b_zero)) begin
            spec_val = FP_DNAN;
          end else if (a_inf || b_zero) begin
            spec_val = {sx, 8'hFF, 23'd0};
          end else if (b_inf || a_zero) begin
            spec_val = {sx, 31'd0};
          end else begin
            special = 1'b0;
          end
        end
        default: special = 1'b0;
      endcase
    end
  end

  // aligned add or subtract of the two magnitudes
  logic               a_big, s_big, s_small;
  logic signed [11:0] e_big, dexp;
  logic [23:0]        m_big, m_small;
  logic [49:0]        sm0, sm, bm, sum;
  logic               lost;

  always_comb begin
    a_big   = (ea > eb) || ((ea == eb) && (ma >= mb));
    e_big   = a_big ? ea : eb;
    s_big   = a_big ? sa : sb;
    s_small = a_big ? sb : sa;
    m_big   = a_big ? ma : mb;
    m_small = a_big ? mb : ma;
    dexp    = a_big ? (ea - eb) : (eb - ea);
    sm0     = {1'b0, m_small, 25'd0};
    bm      = {1'b0, m_big, 25'd0};
    lost    = |(sm0 & ~({50{1'b1}} << dexp[5:0]));
    if (dexp >= 12'sd50) begin
      sm = {49'd0, |m_small};
    end else begin
      sm = (sm0 >> dexp[5:0]) | {49'd0, lost};
    end
    sum = (s_big == s_small) ? (bm + sm) : (bm - sm);
  end

  // one restoring division step
  logic        ge;
  logic [25:0] rd, rn;
  logic [26:0] qn;

  always_comb begin
    ge = (r >= {2'b00, mb});
    rd = ge ? (r - {2'b00, mb}) : r;
    rn = {rd[24:0], 1'b0};
    qn = {q[25:0], ge};
  end

  // denormalize, round and pack
  logic signed [11:0] shv, e2, e3;
  logic [49:0]        m2;
  logic               rlost, g, st, up;
  logic [23:0]        sig, sigf;
  logic [24:0]        s25;
  logic [31:0]        rnd_val;

  always_comb begin
    shv   = -12'sd126 - e;
    rlost = |(m & ~({50{1'b1}} << shv[5:0]));
    if (e < -12'sd126) begin
      e2 = -12'sd126;
      if (shv >= 12'sd50) begin
        m2 = {49'd0, |m};
      end else begin
        m2 = (m >> shv[5:0]) | {49'd0, rlost};
      end
    end else begin
      e2 = e;
      m2 = m;
    end
    sig = m2[49:26];
    g   = m2[25];
    st  = |m2[24:0];
    up  = g && (st || sig[0]);
    s25 = {1'b0, sig} + {24'd0, up};
    if (s25[24]) begin
      sigf = s25[24:1];
      e3   = e2 + 12'sd1;
    end else begin
      sigf = s25[23:0];
      e3   = e2;
    end
    if (e3 > 12'sd127) begin
      rnd_val = {s, 8'hFF, 23'd0};
    end else if (sigf[23]) begin
      rnd_val = {s, e3[7:0] + 8'd127, sigf[22:0]};
    end else begin
      rnd_val = {s, 8'd0, sigf[22:0]};
    end
  end

  // sequencer next state
  always_comb begin
    ph_next = ph;
    unique case (ph)
      F_IDLE: begin
        if (start) begin
          if (special) begin
            ph_next = F_DONE;
          end else begin
            unique case (op)
              OP_ADD, OP_SUB: ph_next = F_ADD;
              OP_MUL:         ph_next = F_MUL;
              OP_DIV:         ph_next = F_PRE;
              default:        ph_next = F_ADD;
            endcase
          end
        end
      end
      F_ADD:  ph_next = F_NORM;
      F_MUL:  ph_next = F_NORM;
      F_PRE:  ph_next = (ma[23] && mb[23]) ? F_DIV : F_PRE;
      F_DIV:  ph_next = (k == 5'd26) ? F_NORM : F_DIV;
      F_NORM: begin
        if (m == 50'd0) begin
          ph_next = F_DONE;
        end else if (m[49]) begin
          ph_next = F_RND;
        end
      end
      F_RND:  ph_next = F_DONE;
      F_DONE: ph_next = F_IDLE;
      default: ph_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= F_IDLE;
    end else begin
      ph <= ph_next;
    end
  end

  assign done = (ph == F_DONE);

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (ph)
      F_IDLE: begin
        if (start) begin
          res <= spec_val;
          sa  <= a[31];
          sb  <= sbe;
          ea  <= unp_exp(a[30:23]);
          eb  <= unp_exp(b[30:23]);
          ma  <= {|a[30:23], a[22:0]};
          mb  <= {|b[30:23], b[22:0]};
          s   <= sx;
          zs  <= ((op == OP_ADD) || (op == OP_SUB)) ? (a[31] & sbe) : sx;
        end
      end
      F_ADD: begin
        m <= sum;
        e <= e_big + 12'sd1;
        s <= s_big;
      end
      F_MUL: begin
        m <= {{24'd0, ma} * {24'd0, mb}, 2'b00};
        e <= ea + eb + 12'sd1;
      end
      F_PRE: begin
        if (!ma[23]) begin
          ma <= {ma[22:0], 1'b0};
          ea <= ea - 12'sd1;
        end
        if (!mb[23]) begin
          mb <= {mb[22:0], 1'b0};
          eb <= eb - 12'sd1;
        end
        r <= {2'b00, ma};
        k <= 5'd0;
      end
      F_DIV: begin
        q <= qn;
        r <= rn;
        k <= k + 5'd1;
        if (k == 5'd26) begin
          m <= {qn, 22'd0, |rn};
          e <= ea - eb;
        end
      end
      F_NORM: begin
        if (m == 50'd0) begin
          res <= {zs, 31'd0};
        end else if (!m[49]) begin
          if (m[49:42] == 8'd0) begin
            m <= {m[41:0], 8'd0};
            e <= e - 12'sd8;
          end else begin
            m <= {m[48:0], 1'b0};
            e <= e - 12'sd1;
          end
        end
      end
      F_RND: res <= rnd_val;
      F_DONE: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/li_datapath.sv -----
// datapath: point stores, weight store, loop counters, float unit, output register
// depends on li_pkg, li_ram, li_fpu
`default_nettype none

module li_datapath #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire li_pkg::cmd_t                  cmd,
  output li_pkg::status_t                    status,
  input  wire logic                          in_valid,
  input  wire logic [li_pkg::IN_USER_W-1:0]  in_user,
  input  wire logic [li_pkg::IN_DATA_W-1:0]  in_data,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [li_pkg::OUT_DATA_W-1:0]      out_data,
  output logic                               out_user
);
  import li_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

  logic [CW-1:0] cnt, i, j;
  logic          ovf;
  logic [31:0]   xi, xp, prod, diff, term, acc;
  logic [31:0]   x_rdata, f_rdata, w_rdata;
  logic [31:0]   fa, fb, fres;
  fpu_op_t       fop;
  step_t         step_q;
  logic          fdone;

  logic          in_fire, ld_fire, ld_store;
  logic [AW-1:0] ld_addr, x_raddr;

  // load path
  assign in_fire  = in_valid && cmd.in_ready;
  assign ld_fire  = in_fire && (in_user[0] == REQ_LOAD);
  assign ld_store = in_user[1] || (cnt < MAXC);
  assign ld_addr  = in_user[1] ? AW'(0) : cnt[AW-1:0];
  assign x_raddr  = cmd.x_at_j ? j[AW-1:0] : i[AW-1:0];

  li_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk   (clk),
    .we    (ld_fire && ld_store),
    .waddr (ld_addr),
    .wdata (in_data[31:0]),
    .re    (cmd.x_re),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  li_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_f_ram (
    .clk   (clk),
    .we    (ld_fire && ld_store),
    .waddr (ld_addr),
    .wdata (in_data[63:32]),
    .re    (cmd.f_re),
    .raddr (i[AW-1:0]),
    .rdata (f_rdata)
  );

  li_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_w_ram (
    .clk   (clk),
    .we    (fdone && (step_q == ST_DIV)),
    .waddr (i[AW-1:0]),
    .wdata (fres),
    .re    (cmd.w_re),
    .raddr (i[AW-1:0]),
    .rdata (w_rdata)
  );

  // point count and sticky drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (ld_fire) begin
      if (in_user[1]) begin
        cnt <= CW'(1);
        ovf <= 1'b0;
      end else if (cnt < MAXC) begin
        cnt <= cnt + CW'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (cmd.i_clr || cmd.query_start) begin
      i <= '0;
    end else if (cmd.i_inc) begin
      i <= i + CW'(1);
    end
    if (cmd.j_clr) begin
      j <= '0;
    end else if (cmd.j_inc) begin
      j <= j + CW'(1);
    end
  end

  // operand selection for the float unit
  always_comb begin
    fa  = xi;
    fb  = x_rdata;
    fop = OP_SUB;
    unique case (cmd.step)
      ST_SUB1: begin fa = xi;      fb = x_rdata; fop = OP_SUB; end
      ST_SUB2: begin fa = xp;      fb = x_rdata; fop = OP_SUB; end
      ST_MULP: begin fa = prod;    fb = diff;    fop = OP_MUL; end
      ST_DIV:  begin fa = f_rdata; fb = prod;    fop = OP_DIV; end
      ST_MULW: begin fa = w_rdata; fb = prod;    fop = OP_MUL; end
      ST_ADD:  begin fa = acc;     fb = term;    fop = OP_ADD; end
      default: begin fa = xi;      fb = x_rdata; fop = OP_SUB; end
    endcase
  end

  li_fpu u_fpu (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.fpu_start),
    .op    (fop),
    .a     (fa),
    .b     (fb),
    .done  (fdone),
    .res   (fres)
  );

  // working registers, results routed by the step that was started
  always_ff @(posedge clk) begin
    if (in_fire && (in_user[0] == REQ_QUERY)) begin
      xp <= in_data[95:64];
    end
    if (cmd.fpu_start) begin
      step_q <= cmd.step;
    end
    if (cmd.ld_xi) begin
      xi <= x_rdata;
    end
    if (cmd.query_start) begin
      acc <= FP_ZERO;
    end
    if (cmd.prod_one) begin
      prod <= FP_ONE;
    end
    if (fdone) begin
      unique case (step_q)
        ST_SUB1, ST_SUB2: diff <= fres;
        ST_MULP:          prod <= fres;
        ST_MULW:          term <= fres;
        ST_ADD:           acc  <= fres;
        default:          ;
      endcase
    end
  end

  // truncate toward zero and clamp to 0..255, nan gives 0
  function automatic logic [7:0] color_of(input logic [31:0] v);
    logic [23:0] iv;
    iv = {1'b1, v[22:0]} >> (8'd150 - v[30:23]);
    if (v[31] || (v[30:0] == 31'd0) || ((&v[30:23]) && (|v[22:0]))) begin
      return 8'd0;
    end else if (v[30:0] >= 31'h437F_0000) begin
      return 8'd255;
    end else if (v[30:23] < 8'd127) begin
      return 8'd0;
    end
    return iv[7:0];
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {color_of(acc), acc};
      out_user <= ovf;
    end
  end

  // status to the controller
  always_comb begin
    status.in_fire  = in_fire;
    status.in_query = (in_user[0] == REQ_QUERY);
    status.n_zero   = (cnt == '0);
    status.j_eq_n   = (j == cnt);
    status.j_eq_i   = (j == i);
    status.i_last   = ((i + CW'(1)) == cnt);
    status.fpu_done = fdone;
    status.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// ----- src/li_ctrl.sv -----
// controller: sequences loads, weight pass and evaluation pass of a query
// depends on li_pkg
`default_nettype none

module li_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire li_pkg::status_t status,
  output li_pkg::cmd_t         cmd
);
  import li_pkg::*;

  ctrl_state_t state, state_next;
  logic        phase2, phase2_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= C_IDLE;
      phase2 <= 1'b0;
    end else begin
      state  <= state_next;
      phase2 <= phase2_next;
    end
  end

  // next state
  always_comb begin
    state_next  = state;
    phase2_next = phase2;
    unique case (state)
      C_IDLE: begin
        if (status.in_fire && status.in_query) begin
          phase2_next = 1'b0;
          state_next  = status.n_zero ? C_OUT : C_RD_XI;
        end
      end
      C_RD_XI: state_next = C_LD_XI;
      C_LD_XI: state_next = C_J;
      C_J: begin
        if (status.j_eq_n) begin
          state_next = phase2 ? C_RD_W : C_RD_F;
        end else if (!status.j_eq_i) begin
          state_next = C_SUB;
        end
      end
      C_SUB:   state_next = C_SUB_W;
      C_SUB_W: state_next = status.fpu_done ? C_MUL : C_SUB_W;
      C_MUL:   state_next = C_MUL_W;
      C_MUL_W: state_next = status.fpu_done ? C_J : C_MUL_W;
      C_RD_F:  state_next = C_DIV;
      C_DIV:   state_next = C_DIV_W;
      C_DIV_W: begin
        if (status.fpu_done) begin
          if (status.i_last) begin
            phase2_next = 1'b1;
            state_next  = C_P2_I;
          end else begin
            state_next  = C_RD_XI;
          end
        end
      end
      C_P2_I:   state_next = C_J;
      C_RD_W:   state_next = C_MULW;
      C_MULW:   state_next = C_MULW_W;
      C_MULW_W: state_next = status.fpu_done ? C_ADD : C_MULW_W;
      C_ADD:    state_next = C_ADD_W;
      C_ADD_W: begin
        if (status.fpu_done) begin
          state_next = status.i_last ? C_OUT : C_P2_I;
        end
      end
      C_OUT:   state_next = status.out_free ? C_IDLE : C_OUT;
      default: state_next = C_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.step = ST_SUB1;
    unique case (state)
      C_IDLE: begin
        cmd.in_ready    = 1'b1;
        cmd.query_start = status.in_fire && status.in_query;
      end
      C_RD_XI: cmd.x_re = 1'b1;
      C_LD_XI: begin
        cmd.ld_xi    = 1'b1;
        cmd.prod_one = 1'b1;
        cmd.j_clr    = 1'b1;
      end
      C_J: begin
        if (!status.j_eq_n) begin
          if (status.j_eq_i) begin
            cmd.j_inc = 1'b1;
          end else begin
            cmd.x_re   = 1'b1;
            cmd.x_at_j = 1'b1;
          end
        end
      end
      C_SUB: begin
        cmd.fpu_start = 1'b1;
        cmd.step      = phase2 ? ST_SUB2 : ST_SUB1;
      end
      C_MUL: begin
        cmd.fpu_start = 1'b1;
        cmd.step      = ST_MULP;
      end
      C_MUL_W: cmd.j_inc = status.fpu_done;
      C_RD_F:  cmd.f_re  = 1'b1;
      C_DIV: begin
        cmd.fpu_start = 1'b1;
        cmd.step      = ST_DIV;
      end
      C_DIV_W: begin
        cmd.i_clr = status.fpu_done && status.i_last;
        cmd.i_inc = status.fpu_done && !status.i_last;
      end
      C_P2_I: begin
        cmd.prod_one = 1'b1;
        cmd.j_clr    = 1'b1;
      end
      C_RD_W: cmd.w_re = 1'b1;
      C_MULW: begin
        cmd.fpu_start = 1'b1;
        cmd.step      = ST_MULW;
      end
      C_ADD: begin
        cmd.fpu_start = 1'b1;
        cmd.step      = ST_ADD;
      end
      C_ADD_W: cmd.i_inc = status.fpu_done && !status.i_last;
      C_OUT:   cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/lagrange_interpolator.sv -----
// Lagrange interpolator over up to MAX_POINTS stored single precision samples.
// A load item (tuser bit 0 low) stores one point; tuser bit 1 restarts
// the set, and loads past MAX_POINTS are dropped and flagged. A query item (tuser bit 0
// high) returns one item: the interpolated float, a clamped color byte and the drop flag.
// All arithmetic goes through one shared multi-cycle float unit, so each inner step of a
// query costs a subtract and a multiply in the float unit plus sequencing, more when a
// subtraction cancels, and each weight costs a divide. Input is taken only while no query
// is in flight.
// Depends on li_pkg, li_ctrl, li_datapath.
`default_nettype none

module lagrange_interpolator #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // point_x [31:0], point_value [63:32], query_x [95:64]
  input  wire logic [li_pkg::IN_DATA_W-1:0]  s_tdata,
  // req_type [0], first_point [1]
  input  wire logic [li_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // interp_value [31:0], color_byte [39:32]
  output logic [li_pkg::OUT_DATA_W-1:0]      m_tdata,
  // points_dropped [0]
  output logic                               m_tuser
);
  import li_pkg::*;

  cmd_t    cmd;
  status_t status;

  li_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  li_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_valid  (s_tvalid),
    .in_user   (s_tuser),
    .in_data   (s_tdata),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

  assign s_tready = cmd.in_ready;

endmodule

`default_nettype wire

// ----- src/lagrange_interpolator_checker.sv -----
// port-level checks of the interpolator, bound to the top level
// depends on lagrange_interpolator_assert.svh
`default_nettype none
`include "lagrange_interpolator_assert.svh"

module lagrange_interpolator_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [95:0] s_tdata,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tuser
);

  logic [31:0] val;
  logic [7:0]  col;
  logic        q_fire;

  assign val    = m_tdata[31:0];
  assign col    = m_tdata[39:32];
  assign q_fire = s_tvalid && s_tready && s_tuser[0] && (s_tdata[0] || !s_tdata[0]);

  // a stalled result item holds
  `LI_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // a query blocks further input on the next cycle
  `LI_ASSERT_NEXT(a_query_busy, clk, rst, q_fire, !s_tready)

  // negative or zero result gives color zero
  `LI_ASSERT_SAME(a_color_low, clk, rst, m_tvalid && (val[31] || (val[30:0] == 31'd0)), col == 8'd0)

  // result from 255 up to infinity gives color 255
  `LI_ASSERT_SAME(a_color_high, clk, rst, m_tvalid && !val[31] && (val[30:0] >= 31'h437F_0000) && (val[30:0] <= 31'h7F80_0000), col == 8'd255)

endmodule

bind lagrange_interpolator lagrange_interpolator_checker u_checker (.*);

`default_nettype wire

// ----- test/tb_lagrange_interpolator.sv -----
// testbench for lagrange_interpolator: directed and random loads and queries,
// predicted by a bit-exact single precision model; depends on li_pkg and the block
`timescale 1ns / 1ps
`default_nettype none

module tb_lagrange_interpolator;
  import li_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  color;
    logic        dropped;
  } interp_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;

  // predictor state
  logic [31:0] abscissa_mem [STORE_DEPTH];
  logic [31:0] ordinate_mem [STORE_DEPTH];
  int          stored_points = 0;
  logic        drop_flag = 1'b0;
  interp_result_t pending_results [$];

  int  mismatch_count = 0;
  int  results_checked = 0;
  int  loads_sent = 0;
  int  queries_sent = 0;
  int  cycle_count = 0;
  bit  idling_on = 1'b1;
  int  hold_off_cycles = 0;
  int  stall_left = 0;

  lagrange_interpolator #(.MAX_POINTS(STORE_DEPTH)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #1 clk = ~clk;

  // ---------------- single precision arithmetic, round to nearest even ----------------

  function automatic bit fp_is_nan(input logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] != 0;
  endfunction

  function automatic bit fp_is_inf(input logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] == 0;
  endfunction

  function automatic bit fp_is_zero(input logic [31:0] a);
    return a[30:0] == 0;
  endfunction

  // split a finite value into integer significand and power of two of its lsb
  function automatic void fp_split(input logic [31:0] a, output logic [127:0] sig,
                                   output int ex);
    if (a[30:23] == 0) begin
      sig = {105'd0, a[22:0]};
      ex  = -149;
    end else begin
      sig = {104'd0, 1'b1, a[22:0]};
      ex  = int'(a[30:23]) - 150;
    end
  endfunction

  // round sig * 2^ex to single precision
  function automatic logic [31:0] fp_round(input logic sgn, input int ex,
                                           input logic [127:0] sig);
    int p;
    int bexp;
    int sh;
    logic [127:0] kept;
    logic [127:0] rem;
    logic [127:0] half;
    if (sig == 0) return {sgn, 31'd0};
    p = 127;
    while (!sig[p]) p--;
    bexp = p + ex + 127;
    sh = p - 23;
    if (bexp < 1) begin
      sh = sh + (1 - bexp);
      bexp = 0;
    end
    if (sh > p + 1) begin
      kept = 0;
    end else if (sh > 0) begin
      kept = sig >> sh;
      rem  = sig & ((128'd1 << sh) - 128'd1);
      half = 128'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 1;
    end else begin
      kept = sig << (-sh);
    end
    if (kept[24]) begin
      kept = kept >> 1;
      bexp++;
    end
    if (bexp == 0 && kept[23]) bexp = 1;
    if (bexp >= 255) return {sgn, 8'hFF, 23'd0};
    return {sgn, bexp[7:0], kept[22:0]};
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] tmp;
    int ea;
    int eb;
    int te;
    logic sa;
    logic sb;
    logic ts;
    if (fp_is_nan(a)) return a | FP_QBIT;
    if (fp_is_nan(b)) return b | FP_QBIT;
    if (fp_is_inf(a) && fp_is_inf(b)) return (a[31] == b[31]) ? a : FP_DNAN;
    if (fp_is_inf(a)) return a;
    if (fp_is_inf(b)) return b;
    if (fp_is_zero(a) && fp_is_zero(b)) return {a[31] & b[31], 31'd0};
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    sa = a[31];
    sb = b[31];
    // keep the larger exponent in a
    if (eb > ea) begin
      tmp = ma; ma = mb; mb = tmp;
      te = ea; ea = eb; eb = te;
      ts = sa; sa = sb; sb = ts;
    end
    // far smaller operand only acts as a sticky bit
    if (ea - eb > 40) begin
      mb = (mb != 0) ? 128'd1 : 128'd0;
      eb = ea - 40;
    end
    ma = ma << (ea - eb);
    if (sa == sb) return fp_round(sa, eb, ma + mb);
    if (ma > mb) return fp_round(sa, eb, ma - mb);
    if (mb > ma) return fp_round(sb, eb, mb - ma);
    return FP_ZERO;
  endfunction

  function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
    if (fp_is_nan(a)) return a | FP_QBIT;
    if (fp_is_nan(b)) return b | FP_QBIT;
    return fp_add(a, {~b[31], b[30:0]});
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] ma;
    logic [127:0] mb;
    int ea;
    int eb;
    logic sgn;
    if (fp_is_nan(a)) return a | FP_QBIT;
    if (fp_is_nan(b)) return b | FP_QBIT;
    if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_zero(a) && fp_is_inf(b))) return FP_DNAN;
    sgn = a[31] ^ b[31];
    if (fp_is_inf(a) || fp_is_inf(b)) return {sgn, 8'hFF, 23'd0};
    if (fp_is_zero(a) || fp_is_zero(b)) return {sgn, 31'd0};
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    return fp_round(sgn, ea + eb, ma * mb);
  endfunction

  function automatic logic [31:0] fp_div(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] quo;
    logic [127:0] rem;
    int ea;
    int eb;
    logic sgn;
    if (fp_is_nan(a)) return a | FP_QBIT;
    if (fp_is_nan(b)) return b | FP_QBIT;
    if ((fp_is_inf(a) && fp_is_inf(b)) || (fp_is_zero(a) && fp_is_zero(b))) return FP_DNAN;
    sgn = a[31] ^ b[31];
    if (fp_is_inf(a) || fp_is_zero(b)) return {sgn, 8'hFF, 23'd0};
    if (fp_is_inf(b) || fp_is_zero(a)) return {sgn, 31'd0};
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    quo = (ma << 60) / mb;
    rem = (ma << 60) % mb;
    return fp_round(sgn, ea - eb - 61, (quo << 1) | (rem != 0));
  endfunction

  // truncate toward zero, clamp to 0..255, nan gives 0
  function automatic logic [7:0] color_of_value(input logic [31:0] v);
    int e;
    logic [23:0] sig;
    if (v[31] || fp_is_nan(v) || fp_is_zero(v)) return 8'd0;
    if (v >= 32'h437F_0000) return 8'd255;
    e = int'(v[30:23]) - 127;
    if (e < 0) return 8'd0;
    sig = {1'b1, v[22:0]};
    return 8'(sig >> (23 - e));
  endfunction

  // lagrange form over the stored points, same operation order as the block
  function automatic logic [31:0] lagrange_at(input logic [31:0] xp);
    logic [31:0] weights [STORE_DEPTH];
    logic [31:0] prod;
    logic [31:0] acc;
    for (int i = 0; i < stored_points; i++) begin
      prod = FP_ONE;
      for (int j = 0; j < stored_points; j++)
        if (j != i) prod = fp_mul(prod, fp_sub(abscissa_mem[i], abscissa_mem[j]));
      weights[i] = fp_div(ordinate_mem[i], prod);
    end
    acc = FP_ZERO;
    for (int i = 0; i < stored_points; i++) begin
      prod = FP_ONE;
      for (int j = 0; j < stored_points; j++)
        if (j != i) prod = fp_mul(prod, fp_sub(xp, abscissa_mem[j]));
      acc = fp_add(acc, fp_mul(weights[i], prod));
    end
    return acc;
  endfunction

  // update the point set or queue the expected answer for one accepted item
  task automatic predict_item(input logic req, input logic first, input logic [31:0] px,
                              input logic [31:0] pv, input logic [31:0] qx);
    interp_result_t r;
    if (req == REQ_LOAD) begin
      loads_sent++;
      if (first) begin
        stored_points = 0;
        drop_flag = 1'b0;
      end
      if (stored_points < STORE_DEPTH) begin
        abscissa_mem[stored_points] = px;
        ordinate_mem[stored_points] = pv;
        stored_points++;
      end else begin
        drop_flag = 1'b1;
      end
    end else begin
      queries_sent++;
      r.value   = lagrange_at(qx);
      r.color   = color_of_value(r.value);
      r.dropped = drop_flag;
      pending_results.push_back(r);
    end
  endtask

  // ---------------- stimulus helpers ----------------

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic req, input logic first, input logic [31:0] px,
                           input logic [31:0] pv, input logic [31:0] qx);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tdata  = {qx, pv, px};
    s_tuser  = {first, req};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(req, first, px, pv, qx);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic load_point(input logic first, input logic [31:0] px, input logic [31:0] pv);
    send_item(REQ_LOAD, first, px, pv, $urandom);
  endtask

  task automatic query_at(input logic [31:0] qx);
    send_item(REQ_QUERY, $urandom_range(0, 1), $urandom, $urandom, qx);
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // moderate magnitude float with random sign and fraction
  function automatic logic [31:0] moderate_float();
    return {1'($urandom), 8'($urandom_range(121, 134)), 23'($urandom)};
  endfunction

  function automatic logic [31:0] any_float();
    case ($urandom_range(0, 19))
      0: return {1'($urandom), 31'd0};
      1: return {1'($urandom), 8'hFF, 23'd0};
      2: return {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
      3: return {1'($urandom), 8'd0, 23'($urandom)};
      4, 5, 6: return $urandom;
      default: return moderate_float();
    endcase
  endfunction

  // ---------------- tests ----------------

  task automatic test_empty_and_single();
    query_at(32'h4000_0000);
    load_point(1'b1, 32'h3F80_0000, 32'h42C8_0000);
    query_at(32'h4040_0000);
    query_at(32'h7FC0_0001);
    query_at(32'hFF80_0000);
  endtask

  task automatic test_color_clamping();
    // line through (1,100) (2,200) (3,300)
    load_point(1'b1, 32'h3F80_0000, 32'h42C8_0000);
    load_point(1'b0, 32'h4000_0000, 32'h4348_0000);
    load_point(1'b0, 32'h4040_0000, 32'h4396_0000);
    query_at(32'h3FC0_0000);
    query_at(32'h4040_0000);
    query_at(32'hBF80_0000);
    query_at(32'h3F00_0000);
    query_at(32'h0000_0000);
    query_at(32'h8000_0001);
  endtask

  task automatic test_special_points();
    // duplicate abscissa gives a division by zero
    load_point(1'b1, 32'h4000_0000, 32'h3F80_0000);
    load_point(1'b0, 32'h4000_0000, 32'h4000_0000);
    query_at(32'h4080_0000);
    // nan ordinate and denormal abscissas
    load_point(1'b1, 32'h0000_0001, 32'hFFFF_FFFF);
    load_point(1'b0, 32'h807F_FFFF, 32'h7F7F_FFFF);
    query_at(32'h0000_0000);
    load_point(1'b1, 32'h7F80_0000, 32'h4000_0000);
    load_point(1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
    query_at(32'h3F80_0000);
  endtask

  task automatic test_store_overflow();
    load_point(1'b1, 32'h3F80_0000, 32'h4000_0000);
    for (int k = 1; k < STORE_DEPTH + 2; k++)
      load_point(1'b0, {1'b0, 8'($urandom_range(125, 133)), 23'($urandom)}, moderate_float());
    query_at(moderate_float());
    // restart clears the drop flag
    load_point(1'b1, 32'h4000_0000, 32'h4348_0000);
    load_point(1'b0, 32'h40A0_0000, 32'h4270_0000);
    query_at(32'h4040_0000);
  endtask

  task automatic test_random_sets(input int item_budget);
    int sent;
    int npts;
    sent = 0;
    while (sent < item_budget) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any item with any content
        send_item(1'($urandom), 1'($urandom), any_float(), any_float(), any_float());
        sent++;
      end else begin
        npts = $urandom_range(1, 7);
        for (int k = 0; k < npts; k++) begin
          load_point(k == 0 && $urandom_range(0, 4) != 0,
                     ($urandom_range(0, 9) == 0) ? any_float() : moderate_float(),
                     ($urandom_range(0, 9) == 0) ? any_float() : moderate_float());
          sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          query_at(($urandom_range(0, 5) == 0) ? any_float() : moderate_float());
          sent++;
        end
      end
    end
  endtask

  task automatic test_output_backpressure();
    load_point(1'b1, 32'h3F80_0000, 32'h4270_0000);
    load_point(1'b0, 32'h4040_0000, 32'h4316_0000);
    hold_off_cycles = 400;
    repeat (4) query_at(moderate_float());
    load_point(1'b0, 32'h40A0_0000, 32'h4000_0000);
    wait_results_drained();
    query_at(32'h4000_0000);
  endtask

  // ---------------- receiver and checker ----------------

  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      m_tready = 1'b0;
      hold_off_cycles--;
    end else if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      m_tready = 1'b0;
      stall_left = $urandom_range(1, 11) - 1;
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    interp_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result item: value %h color %0d dropped %b",
                   m_tdata[31:0], m_tdata[39:32], m_tuser);
      end else begin
        exp_r = pending_results.pop_front();
        results_checked++;
        if (m_tdata[31:0] !== exp_r.value || m_tdata[39:32] !== exp_r.color ||
            m_tuser !== exp_r.dropped) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: expected value %h color %0d dropped %b, got %h %0d %b",
                     results_checked, exp_r.value, exp_r.color, exp_r.dropped,
                     m_tdata[31:0], m_tdata[39:32], m_tuser);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------- sequence ----------------

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_and_single();
    test_color_clamping();
    test_special_points();
    wait_results_drained();
    test_store_overflow();
    test_output_backpressure();
    test_random_sets(25);
    idling_on = 1'b0;
    test_random_sets(12);
    wait_results_drained();
    if (pending_results.size() != 0) mismatch_count++;
    $display("covered %0d loads and %0d queries, %0d results checked in %0d cycles",
             loads_sent, queries_sent, results_checked, cycle_count);
    $display("including empty, duplicate, special value, overflow and stall cases");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
